// ===== design/sxp_pkg.sv =====
// Shared types and codes for the S-expression stream parser.
`default_nettype none

package sxp_pkg;

    // Event codes carried on the result stream
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_HEAD_CHAR = 3'd1;
    localparam logic [2:0] EV_ATOM_CHAR = 3'd2;
    localparam logic [2:0] EV_NAME_END  = 3'd3;
    localparam logic [2:0] EV_CLOSE     = 3'd4;
    localparam logic [2:0] EV_DONE      = 3'd5;
    localparam logic [2:0] EV_ERROR     = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_EXPECT_OPEN   = 3'd1;
    localparam logic [2:0] ERR_EXPECT_NAME   = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR      = 3'd3;
    localparam logic [2:0] ERR_EARLY_END     = 3'd4;
    localparam logic [2:0] ERR_UNBALANCED    = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW      = 3'd6;

    // Character constants
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // One result item
    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
        logic [7:0] dep;
        logic [2:0] err;
        logic       last;
    } t_result;

    // All results of one input item (one or two)
    typedef struct packed {
        logic    two;
        t_result res1;
        t_result res0;
    } t_entry;

endpackage

`default_nettype wire

// ===== design/sxp_front.sv =====
// Front end: accepts bytes, runs the grammar state machine, builds result entries.
`default_nettype none

module sxp_front
    import sxp_pkg::*;
#(
    parameter logic [7:0] DEPTH_LIMIT = 8'd255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_action,
    input  wire logic [7:0] i_char,
    input  wire logic       i_full,
    output logic            o_push,
    output t_entry          o_entry
);

    typedef enum logic [2:0] {
        PH_TOP_OPEN,
        PH_EXPECT_HEAD,
        PH_IN_NAME,
        PH_LIST,
        PH_AFTER_TOP,
        PH_FAILED
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_depth, n_depth;
    logic       r_head,  n_head;

    logic       accept;
    logic       is_sp, is_let;
    logic [7:0] upper;
    logic [7:0] lc_depth;
    logic       overflow;

    logic       l_emit;
    t_result    l_res;
    t_phase     l_phase;
    logic [7:0] l_depth;

    logic       e0, e1;
    t_result    res0, res1;

    function automatic t_result err_res(input logic [2:0] code);
        t_result r;
        r     = '0;
        r.ev  = EV_ERROR;
        r.err = code;
        return r;
    endfunction

    function automatic t_result ev_res(input logic [2:0] ev, input logic [7:0] ch,
                                       input logic [7:0] dep);
        t_result r;
        r     = '0;
        r.ev  = ev;
        r.ch  = ch;
        r.dep = dep;
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Byte classes
    assign upper  = i_char & ~CH_CASE;
    assign is_sp  = (i_char == CH_SPACE) || (i_char == CH_NEWLINE);
    assign is_let = (upper >= CH_UPPER_A) && (upper <= CH_UPPER_Z) && !i_char[7];

    // A head name ending opens its list one level down
    assign lc_depth = (r_phase == PH_IN_NAME && r_head) ? r_depth + 8'd1 : r_depth;
    assign overflow = r_head && (r_depth >= DEPTH_LIMIT);

    // Byte handling inside a list
    always_comb begin
        l_emit  = 1'b0;
        l_res   = '0;
        l_phase = PH_LIST;
        l_depth = lc_depth;
        if (is_sp) begin
            l_phase = PH_LIST;
        end else if (i_char == CH_OPEN) begin
            l_phase = PH_EXPECT_HEAD;
        end else if (is_let) begin
            l_phase = PH_IN_NAME;
            l_emit  = 1'b1;
            l_res   = ev_res(EV_ATOM_CHAR, i_char, lc_depth);
        end else if (i_char == CH_CLOSE) begin
            l_emit = 1'b1;
            if (lc_depth == 8'd0) begin
                l_res   = err_res(ERR_UNBALANCED);
                l_phase = PH_FAILED;
            end else begin
                l_depth = lc_depth - 8'd1;
                l_res   = ev_res(EV_CLOSE, 8'd0, lc_depth - 8'd1);
                if (lc_depth == 8'd1) begin
                    l_phase = PH_AFTER_TOP;
                end
            end
        end else begin
            l_emit  = 1'b1;
            l_res   = err_res(ERR_BAD_CHAR);
            l_phase = PH_FAILED;
        end
    end

    // Grammar step
    always_comb begin
        n_phase = r_phase;
        n_depth = r_depth;
        n_head  = r_head;
        e0      = 1'b0;
        e1      = 1'b0;
        res0    = '0;
        res1    = '0;
        if (i_action) begin
            unique case (r_phase)
                PH_TOP_OPEN: begin
                    e0   = 1'b1;
                    res0 = err_res(ERR_EXPECT_OPEN);
                end
                PH_EXPECT_HEAD: begin
                    e0   = 1'b1;
                    res0 = err_res(ERR_EXPECT_NAME);
                end
                PH_IN_NAME: begin
                    e0   = 1'b1;
                    res0 = ev_res(EV_NAME_END, 8'd0, r_depth);
                    e1   = 1'b1;
                    res1 = overflow ? err_res(ERR_OVERFLOW) : err_res(ERR_EARLY_END);
                end
                PH_LIST: begin
                    e0   = 1'b1;
                    res0 = err_res(ERR_EARLY_END);
                end
                PH_AFTER_TOP: begin
                    e0   = 1'b1;
                    res0 = ev_res(EV_DONE, 8'd0, 8'd0);
                end
                default: begin
                    e0 = 1'b0;
                end
            endcase
            n_phase = PH_TOP_OPEN;
            n_depth = 8'd0;
            n_head  = 1'b0;
        end else begin
            unique case (r_phase)
                PH_TOP_OPEN: begin
                    if (!is_sp) begin
                        if (i_char == CH_OPEN) begin
                            n_phase = PH_EXPECT_HEAD;
                        end else begin
                            e0      = 1'b1;
                            res0    = err_res(ERR_EXPECT_OPEN);
                            n_phase = PH_FAILED;
                        end
                    end
                end
                PH_EXPECT_HEAD: begin
                    if (!is_sp) begin
                        e0 = 1'b1;
                        if (is_let) begin
                            n_head  = 1'b1;
                            n_phase = PH_IN_NAME;
                            res0    = ev_res(EV_HEAD_CHAR, i_char, r_depth);
                        end else begin
                            res0    = err_res(ERR_EXPECT_NAME);
                            n_phase = PH_FAILED;
                        end
                    end
                end
                PH_IN_NAME: begin
                    e0 = 1'b1;
                    if (is_let) begin
                        res0 = ev_res(r_head ? EV_HEAD_CHAR : EV_ATOM_CHAR, i_char, r_depth);
                    end else begin
                        // Name end, then the ending byte as in a list
                        res0   = ev_res(EV_NAME_END, 8'd0, r_depth);
                        n_head = 1'b0;
                        if (overflow) begin
                            e1      = 1'b1;
                            res1    = err_res(ERR_OVERFLOW);
                            n_phase = PH_FAILED;
                        end else begin
                            e1      = l_emit;
                            res1    = l_res;
                            n_phase = l_phase;
                            n_depth = l_depth;
                        end
                    end
                end
                PH_LIST: begin
                    e0      = l_emit;
                    res0    = l_res;
                    n_phase = l_phase;
                    n_depth = l_depth;
                    n_head  = 1'b0;
                end
                PH_AFTER_TOP: begin
                    if (!is_sp) begin
                        e0      = 1'b1;
                        res0    = err_res(ERR_UNBALANCED);
                        n_phase = PH_FAILED;
                    end
                end
                default: begin
                    e0 = 1'b0;
                end
            endcase
        end
    end

    // Entry toward the queue, last flag on the final result
    always_comb begin
        o_entry          = '0;
        o_entry.two      = e1;
        o_entry.res0     = res0;
        o_entry.res1     = res1;
        o_entry.res0.last = !e1;
        o_entry.res1.last = e1;
    end

    assign o_push = accept && e0;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP_OPEN;
            r_depth <= 8'd0;
            r_head  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_depth <= n_depth;
            r_head  <= n_head;
        end
    end

endmodule

`default_nettype wire

// ===== design/sxp_queue.sv =====
// Short queue of result entries between the front and back ends.
`default_nettype none

module sxp_queue
    import sxp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_entry      o_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== design/sxp_back.sv =====
// Back end: splits queued entries into single results behind an output register.
`default_nettype none

module sxp_back
    import sxp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_result     o_result
);

    logic    r_valid;
    logic    r_second;
    t_result r_out;
    logic    load;
    t_result pick;

    // Load when the output register is empty or being drained
    assign load  = i_valid && (!r_valid || i_ready);
    assign pick  = (i_entry.two && r_second) ? i_entry.res1 : i_entry.res0;
    assign o_pop = load && (!i_entry.two || r_second);

    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_out    <= pick;
            r_second <= i_entry.two && !r_second;
        end else if (i_ready) begin
            r_valid  <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/sexpr_stream_parser_unit.sv =====
// Top level of the S-expression stream parser.
//
//  Port group   Dir  tdata                                     tuser         tlast
//  s_axis       in   [7:0] char_code                           [0] action    -
//  m_axis       out  [7:0] char_out, [15:8] depth,             [2:0] event   last
//                    [18:16] error_code, [23:19] zero
//
// One byte is taken per cycle; the grammar state updates in the cycle it is accepted.
// An input gives zero, one or two results; the back end sends one result per cycle while
// m_axis_tready is high, so a byte that ends a name may send two results one after the other.
// Results reach m_axis through the result queue and then the output register.
// Input stalls only when the result queue is full; reset is synchronous, active low.
`default_nettype none

module sexpr_stream_parser_unit
    import sxp_pkg::*;
#(
    parameter int MAX_DEPTH   = 255,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] char_out, [15:8] depth, [18:16] error_code
    output logic [2:0]       m_axis_tuser,   // [2:0] event_res
    output logic             m_axis_tlast    // last
);

    localparam logic [7:0] DEPTH_LIMIT = (MAX_DEPTH >= 255) ? 8'd255 : 8'(MAX_DEPTH);

    logic    q_push, q_full, q_valid, q_pop;
    t_entry  f_entry, q_entry;
    t_result out_res;

    sxp_front #(
        .DEPTH_LIMIT(DEPTH_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_char   (s_axis_tdata),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_entry  (f_entry)
    );

    sxp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    sxp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    // Output packing
    assign m_axis_tdata = {5'd0, out_res.err, out_res.dep, out_res.ch};
    assign m_axis_tuser = out_res.ev;
    assign m_axis_tlast = out_res.last;

    // Checks
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_event_not_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != EV_NONE))
        else $error("result with no event");

    a_char_only_for_names: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_HEAD_CHAR && m_axis_tuser != EV_ATOM_CHAR)
        |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("character on a non-name event");

    a_error_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == EV_ERROR) == (m_axis_tdata[18:16] != ERR_NONE)))
        else $error("error code does not match event");

endmodule

`default_nettype wire
